@@ hdl/vafs_pkg.sv @@
// Package for the view area factor score block: item types, op codes and FSM states.
`timescale 1ns / 1ps

package vafs_pkg;

  localparam int OCC_BITS  = 16;
  localparam int INFO_BITS = 18;
  localparam int OUT_BITS  = 32;

  localparam logic [2:0] OP_NEW_RAY   = 3'd0;
  localparam logic [2:0] OP_RAY_VOXEL = 3'd1;
  localparam logic [2:0] OP_END_VOXEL = 3'd2;
  localparam logic [2:0] OP_VOID_RAY  = 3'd3;
  localparam logic [2:0] OP_QUERY     = 3'd4;

  // Register indexes on the APB port (byte address is index * 4)
  localparam logic REG_FREE_LIMIT = 1'b0;
  localparam logic REG_OCC_LIMIT  = 1'b1;

  typedef struct packed {
    logic [2:0]          op;
    logic                node_present;
    logic                has_measurement;
    logic                occluded;
    logic [OCC_BITS-1:0] occupancy;
  } in_item_t;

  typedef struct packed {
    logic [INFO_BITS-1:0] information;
    logic [OUT_BITS-1:0]  occupied_total;
    logic [OUT_BITS-1:0]  occplane_total;
    logic [OUT_BITS-1:0]  unobserved_total;
  } out_item_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_DIV,
    S_TSEL,
    S_SQ,
    S_CUBE,
    S_DONE
  } vafs_state_t;

endpackage

@@ hdl/view_area_factor_score_top.sv @@
// Top level of the view area factor score block: ray classification and query scoring.
`timescale 1ns / 1ps

// Usage:
//   The input channel (in_valid/in_ready/in_data) carries one item per transfer: new ray,
//   ray voxel, end voxel, void ray or query. Ray items are absorbed directly in the idle state and
//   give no result, so while the block is idle a ray stream runs at one voxel per cycle.
//   A query snapshots the three ray counters and runs a small sequencer over one shared
//   restoring divider step and one shared multiplier: per fraction a setup step,
//   FRACTION_BITS+1 divide steps, a select step and the square and cube multiply steps.
//   The result is loaded into the output register in the done state (the fractions are
//   skipped when all counters are zero) and in_ready stays low until the block is idle again.
//   The result channel (out_valid/out_ready/out_data) is a single output register. While
//   a result waits for out_ready, ray items are still taken; a following query computes
//   and then holds in its last state until the register is free.
//   The APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds free_limit at
//   address 0 and occupied_limit at address 4; pready is always high. Write it only
//   while the block is idle.
//   Reset (rst_n low, synchronous) clears the counters, restores the per-ray state and
//   the limit defaults, and empties the output register.
module view_area_factor_score_top
  import vafs_pkg::*;
#(
  parameter int COUNT_BITS    = 32,
  parameter int FRACTION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CB  = COUNT_BITS;
  localparam int F   = FRACTION_BITS;
  localparam int TW  = CB + 2;
  localparam int RW  = TW + 1;
  localparam int QW  = F + 2;
  localparam int XW  = F + 1;
  localparam int BW  = F + 2;
  localparam int PW  = XW + BW;
  localparam int FW  = F + 4;
  localparam int IW  = F + 2;
  localparam int IEW = (IW > INFO_BITS) ? IW : INFO_BITS;
  localparam int CW  = (CB > OUT_BITS) ? CB : OUT_BITS;
  localparam int ITW = $clog2(F + 1);

  localparam logic [15:0] FREE_LIMIT_RST = 16'd13107;
  localparam logic [15:0] OCC_LIMIT_RST  = 16'd52429;

  localparam logic [XW-1:0] ONE      = {1'b1, {F{1'b0}}};
  localparam logic [BW-1:0] THREE    = {2'b11, {F{1'b0}}};
  localparam logic [PW-1:0] HALF     = PW'(1) << (F - 1);
  localparam logic [FW-1:0] ONE_W    = FW'(ONE);
  localparam logic [FW-1:0] FOUR_W   = FW'(ONE) << 2;
  localparam logic [CW-1:0] OUT_MAX  = CW'({OUT_BITS{1'b1}});

  vafs_state_t state_r, state_nxt;

  logic [15:0]   free_limit_r, occ_limit_r;
  logic [CB-1:0] occ_hits_r, occ_hits_nxt;
  logic [CB-1:0] occp_hits_r, occp_hits_nxt;
  logic [CB-1:0] unobs_r, unobs_nxt;
  logic          prev_free_r, prev_free_nxt;
  logic          ray_reg_r, ray_reg_nxt;
  logic          no_known_r, no_known_nxt;

  logic [TW-1:0]  total_r, total_nxt;
  logic [RW-1:0]  rem_r, rem_nxt;
  logic [QW-1:0]  quo_r, quo_nxt;
  logic [ITW-1:0] iter_r, iter_nxt;
  logic           sel_r, sel_nxt;
  logic [XW-1:0]  t_r, t_nxt;
  logic [XW-1:0]  t2_r, t2_nxt;
  logic [IW-1:0]  info_r, info_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  logic in_fire, cfg_wr, out_free;

  // voxel classification
  logic v_prev_free, v_ray_reg, v_no_known, v_inc_occ, v_inc_occp, v_registered;

  // datapath helpers
  logic [TW-1:0]  count_sel;
  logic           init_ge;
  logic [RW-1:0]  rem_dbl;
  logic [QW:0]    quo_rnd;
  logic [XW-1:0]  x_frac, one_m_x;
  logic [FW-1:0]  x5, omx5, t_wide;
  logic [XW-1:0]  mul_a;
  logic [BW-1:0]  mul_b;
  logic [PW-1:0]  prod, prod_rnd;
  logic [PW-F-1:0] s_wide;
  logic [XW-1:0]  s_cap;
  logic [IEW-1:0] info_ext;

  assign in_fire  = in_valid && in_ready;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign out_free = !out_valid_r || out_ready;

  // APB port
  assign pready = 1'b1;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_OCC_LIMIT) begin
      prdata[15:0] = occ_limit_r;
    end else begin
      prdata[15:0] = free_limit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_limit_r <= FREE_LIMIT_RST;
      occ_limit_r  <= OCC_LIMIT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FREE_LIMIT) begin
        free_limit_r <= pwdata[15:0];
      end else begin
        occ_limit_r <= pwdata[15:0];
      end
    end
  end

  // Classify one voxel against the per-ray state.
  always_comb begin
    v_prev_free  = prev_free_r;
    v_ray_reg    = ray_reg_r;
    v_no_known   = no_known_r;
    v_inc_occ    = 1'b0;
    v_inc_occp   = 1'b0;
    v_registered = ray_reg_r;
    if (!ray_reg_r) begin
      if (!in_data.node_present) begin
        v_prev_free = no_known_r;
      end else if (!in_data.has_measurement && in_data.occluded) begin
        v_inc_occp   = 1'b1;
        v_ray_reg    = 1'b1;
        v_prev_free  = 1'b0;
        v_registered = 1'b1;
      end else begin
        v_no_known = 1'b0;
        if (in_data.occupancy >= occ_limit_r) begin
          v_inc_occ    = prev_free_r;
          v_prev_free  = 1'b0;
          v_ray_reg    = 1'b1;
          v_registered = 1'b1;
        end else begin
          v_prev_free = (in_data.occupancy <= free_limit_r);
        end
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_fire && in_data.op == OP_QUERY) state_nxt = S_INIT;
      end
      S_INIT: begin
        state_nxt = (total_r == '0) ? S_DONE : S_DIV;
      end
      S_DIV: begin
        if (iter_r == ITW'(F)) state_nxt = S_TSEL;
      end
      S_TSEL: state_nxt = S_SQ;
      S_SQ:   state_nxt = S_CUBE;
      S_CUBE: state_nxt = sel_r ? S_DONE : S_INIT;
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Shared arithmetic
  always_comb begin
    count_sel = sel_r ? TW'(occp_hits_r) : TW'(occ_hits_r);
    init_ge   = (count_sel >= total_r);
    rem_dbl   = {rem_r[RW-2:0], 1'b0};
    quo_rnd   = {1'b0, quo_r} + (QW+1)'(1);
    x_frac    = quo_rnd[XW:1];
    one_m_x   = ONE - x_frac;
    x5        = (FW'(x_frac) << 2) + FW'(x_frac);
    omx5      = (FW'(one_m_x) << 2) + FW'(one_m_x);
    if (!sel_r) begin
      t_wide = (x5 <= ONE_W) ? x5 : ((omx5 + FW'(2)) >> 2);
    end else begin
      t_wide = (x5 <= FOUR_W) ? ((x5 + FW'(2)) >> 2) : omx5;
    end
    if (state_r == S_CUBE) begin
      mul_a = t2_r;
      mul_b = THREE - {t_r, 1'b0};
    end else begin
      mul_a = t_r;
      mul_b = BW'(t_r);
    end
    prod     = PW'(mul_a) * PW'(mul_b);
    prod_rnd = prod + HALF;
    s_wide   = prod_rnd[PW-1:F];
    s_cap    = (s_wide > (PW-F)'(ONE)) ? ONE : s_wide[XW-1:0];
  end

  // Register updates
  always_comb begin
    occ_hits_nxt  = occ_hits_r;
    occp_hits_nxt = occp_hits_r;
    unobs_nxt     = unobs_r;
    prev_free_nxt = prev_free_r;
    ray_reg_nxt   = ray_reg_r;
    no_known_nxt  = no_known_r;
    total_nxt     = total_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    iter_nxt      = iter_r;
    sel_nxt       = sel_r;
    t_nxt         = t_r;
    t2_nxt        = t2_r;
    info_nxt      = info_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    in_ready      = (state_r == S_IDLE);

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_data.op)
            OP_NEW_RAY: begin
              prev_free_nxt = 1'b1;
              ray_reg_nxt   = 1'b0;
              no_known_nxt  = 1'b1;
            end
            OP_RAY_VOXEL, OP_END_VOXEL: begin
              prev_free_nxt = v_prev_free;
              ray_reg_nxt   = v_ray_reg;
              no_known_nxt  = v_no_known;
              if (v_inc_occ && occ_hits_r != '1) occ_hits_nxt = occ_hits_r + 1'b1;
              if (v_inc_occp && occp_hits_r != '1) occp_hits_nxt = occp_hits_r + 1'b1;
              if (in_data.op == OP_END_VOXEL && !v_registered && unobs_r != '1) begin
                unobs_nxt = unobs_r + 1'b1;
              end
            end
            OP_VOID_RAY: begin
              if (unobs_r != '1) unobs_nxt = unobs_r + 1'b1;
            end
            OP_QUERY: begin
              total_nxt = TW'(occ_hits_r) + TW'(occp_hits_r) + TW'(unobs_r);
              sel_nxt   = 1'b0;
              info_nxt  = '0;
            end
            default: ;
          endcase
        end
      end
      S_INIT: begin
        rem_nxt  = RW'(count_sel - (init_ge ? total_r : '0));
        quo_nxt  = QW'(init_ge);
        iter_nxt = '0;
      end
      S_DIV: begin
        if (rem_dbl >= RW'(total_r)) begin
          rem_nxt = rem_dbl - RW'(total_r);
          quo_nxt = {quo_r[QW-2:0], 1'b1};
        end else begin
          rem_nxt = rem_dbl;
          quo_nxt = {quo_r[QW-2:0], 1'b0};
        end
        iter_nxt = iter_r + 1'b1;
      end
      S_TSEL: begin
        t_nxt = (t_wide > ONE_W) ? ONE : t_wide[XW-1:0];
      end
      S_SQ: begin
        t2_nxt = prod_rnd[F +: XW];
      end
      S_CUBE: begin
        info_nxt = info_r + IW'(s_cap);
        sel_nxt  = 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt                 = 1'b1;
          out_data_nxt.information      = info_ext[INFO_BITS-1:0];
          out_data_nxt.occupied_total   = (CW'(occ_hits_r) > OUT_MAX) ?
                                          '1 : OUT_BITS'(occ_hits_r);
          out_data_nxt.occplane_total   = (CW'(occp_hits_r) > OUT_MAX) ?
                                          '1 : OUT_BITS'(occp_hits_r);
          out_data_nxt.unobserved_total = (CW'(unobs_r) > OUT_MAX) ?
                                          '1 : OUT_BITS'(unobs_r);
        end
      end
      default: ;
    endcase
  end

  assign info_ext = IEW'(info_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_hits_r  <= '0;
      occp_hits_r <= '0;
      unobs_r     <= '0;
      prev_free_r <= 1'b1;
      ray_reg_r   <= 1'b0;
      no_known_r  <= 1'b1;
      out_valid_r <= 1'b0;
      sel_r       <= 1'b0;
      iter_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      occ_hits_r  <= occ_hits_nxt;
      occp_hits_r <= occp_hits_nxt;
      unobs_r     <= unobs_nxt;
      prev_free_r <= prev_free_nxt;
      ray_reg_r   <= ray_reg_nxt;
      no_known_r  <= no_known_nxt;
      out_valid_r <= out_valid_nxt;
      sel_r       <= sel_nxt;
      iter_r      <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    total_r    <= total_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    t_r        <= t_nxt;
    t2_r       <= t2_nxt;
    info_r     <= info_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_data.op == OP_QUERY) |=> (state_r == S_INIT))
    else $error("query transfer did not start the sequencer");

  a_registered_not_free: assert property (@(posedge clk) disable iff (!rst_n)
    ray_reg_r |-> !prev_free_r)
    else $error("registered ray still marked as after free space");

  a_counters_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n |=> (occ_hits_r >= $past(occ_hits_r) && occp_hits_r >= $past(occp_hits_r)
               && unobs_r >= $past(unobs_r)))
    else $error("ray counter decreased");

  a_info_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |-> (info_r <= (IW'(ONE) << 1)))
    else $error("score sum above two");
`endif

endmodule
